/* src/irot_pkg.sv */
// ----------------------------------------------------------------------------
// irot_pkg: shared constants for the 90-degree image rotator
// Holds input mode codes, side length width and reset, and result queue depth.
// ----------------------------------------------------------------------------
package irot_pkg;

  // Input item modes.
  localparam logic MODE_PUSH  = 1'b0;  // write one pixel, emit if a frame is held
  localparam logic MODE_DRAIN = 1'b1;  // emit only

  // Width of the side length register.
  localparam int unsigned SIDE_CFG_W = 6;

  // Reset value of the side length register.
  localparam int unsigned SIDE_RESET = 32;

  // Entries in the result queue between the front and the output.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

endpackage

/* src/irot_front.sv */
// ----------------------------------------------------------------------------
// irot_front: item intake, pointer control and ping-pong frame store
// Accepts items, writes pixels into the filling bank and reads the held
// frame in rotated order. Read data leaves one cycle after acceptance.
// ----------------------------------------------------------------------------
module irot_front #(
  parameter int unsigned MAX_SIDE   = 32,
  parameter int unsigned PIXEL_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Item input.
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               mode_i,
  input  logic [PIXEL_BITS-1:0]              pixel_in_i,
  // Configuration write.
  input  logic                               cfg_write_i,
  input  logic [irot_pkg::SIDE_CFG_W-1:0]    side_length_i,
  // Toward the result queue.
  input  logic                               q_can_accept_i,
  output logic                               rd_push_o,
  output logic [PIXEL_BITS-1:0]              rd_pixel_o,
  output logic                               rd_last_o
);

  localparam int unsigned PosW  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int unsigned AddrW = 2 * PosW + 1;
  localparam int unsigned Depth = 2 ** AddrW;

  logic [PosW-1:0] side_m1_q, side_m1_d;
  logic [PosW-1:0] wr_row_q, wr_row_d, wr_col_q, wr_col_d;
  logic [PosW-1:0] rd_row_q, rd_row_d, rd_col_q, rd_col_d;
  logic            wr_bank_q, wr_bank_d;
  logic            held_q, held_d;
  logic            pend_q, last_q;

  logic [PIXEL_BITS-1:0] mem [Depth];
  logic [PIXEL_BITS-1:0] rd_data_q;

  logic            accept;
  logic            do_write;
  logic            emit;
  logic            last;
  logic            frame_done;
  logic [PosW-1:0] src_row;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [31:0]     side_ext;
  logic [PosW-1:0] side_cfg_m1;

  assign in_ready_o = q_can_accept_i;
  assign accept     = in_valid_i & in_ready_o;
  assign emit       = accept & held_q;
  assign do_write   = accept & (mode_i == irot_pkg::MODE_PUSH);

  assign src_row    = side_m1_q - rd_col_q;
  assign last       = (rd_row_q == side_m1_q) && (rd_col_q == side_m1_q);
  assign frame_done = (wr_row_q == side_m1_q) && (wr_col_q == side_m1_q);
  assign wr_addr    = {wr_bank_q, wr_row_q, wr_col_q};
  assign rd_addr    = {~wr_bank_q, src_row, rd_row_q};

  // Side length clamped to 1..MAX_SIDE, stored minus one.
  assign side_ext = 32'(side_length_i);
  always_comb begin
    if (side_ext == 32'd0) begin
      side_cfg_m1 = '0;
    end else if (side_ext > 32'(MAX_SIDE)) begin
      side_cfg_m1 = PosW'(MAX_SIDE - 1);
    end else begin
      side_cfg_m1 = PosW'(side_ext - 32'd1);
    end
  end

  always_comb begin
    side_m1_d = side_m1_q;
    wr_row_d  = wr_row_q;
    wr_col_d  = wr_col_q;
    rd_row_d  = rd_row_q;
    rd_col_d  = rd_col_q;
    wr_bank_d = wr_bank_q;
    held_d    = held_q;
    if (cfg_write_i) begin
      side_m1_d = side_cfg_m1;
      wr_row_d  = '0;
      wr_col_d  = '0;
      rd_row_d  = '0;
      rd_col_d  = '0;
      held_d    = 1'b0;
    end else begin
      if (emit) begin
        if (last) begin
          held_d   = 1'b0;
          rd_row_d = '0;
          rd_col_d = '0;
        end else if (rd_col_q == side_m1_q) begin
          rd_col_d = '0;
          rd_row_d = rd_row_q + 1'b1;
        end else begin
          rd_col_d = rd_col_q + 1'b1;
        end
      end
      if (do_write) begin
        if (wr_col_q == side_m1_q) begin
          wr_col_d = '0;
          if (frame_done) begin
            wr_row_d  = '0;
            wr_bank_d = ~wr_bank_q;
            held_d    = 1'b1;
            rd_row_d  = '0;
            rd_col_d  = '0;
          end else begin
            wr_row_d = wr_row_q + 1'b1;
          end
        end else begin
          wr_col_d = wr_col_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_m1_q <= PosW'(((irot_pkg::SIDE_RESET > MAX_SIDE) ?
                          MAX_SIDE : irot_pkg::SIDE_RESET) - 1);
      wr_row_q  <= '0;
      wr_col_q  <= '0;
      rd_row_q  <= '0;
      rd_col_q  <= '0;
      wr_bank_q <= 1'b0;
      held_q    <= 1'b0;
      pend_q    <= 1'b0;
    end else begin
      side_m1_q <= side_m1_d;
      wr_row_q  <= wr_row_d;
      wr_col_q  <= wr_col_d;
      rd_row_q  <= rd_row_d;
      rd_col_q  <= rd_col_d;
      wr_bank_q <= wr_bank_d;
      held_q    <= held_d;
      pend_q    <= emit;
    end
  end

  // Frame store: one write into the filling bank, one read of the held bank.
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem[wr_addr] <= pixel_in_i;
    end
    if (emit) begin
      rd_data_q <= mem[rd_addr];
      last_q    <= last;
    end
  end

  assign rd_push_o  = pend_q;
  assign rd_pixel_o = rd_data_q;
  assign rd_last_o  = last_q;

endmodule

/* src/irot_queue.sv */
// ----------------------------------------------------------------------------
// irot_queue: result queue
// Small FIFO that holds rotated pixels until the output side takes them.
// ----------------------------------------------------------------------------
module irot_queue #(
  parameter int unsigned PIXEL_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [PIXEL_BITS-1:0] push_pixel_i,
  input  logic                  push_last_i,
  output logic                  can_accept_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIXEL_BITS-1:0] pixel_out_o,
  output logic                  frame_last_o
);

  localparam int unsigned PtrW = irot_pkg::QUEUE_PTR_W;
  localparam int unsigned CntW = irot_pkg::QUEUE_CNT_W;

  logic [PIXEL_BITS-1:0] pix_q  [irot_pkg::QUEUE_DEPTH];
  logic                  last_q [irot_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  pop;
  logic [CntW:0]         reserved;

  assign out_valid_o  = (count_q != '0);
  assign pop          = out_valid_o & out_ready_i;
  assign pixel_out_o  = pix_q[rd_ptr_q];
  assign frame_last_o = last_q[rd_ptr_q];

  // A read already in flight in the front holds a slot of its own.
  assign reserved     = {1'b0, count_q} + (CntW + 1)'(push_i);
  assign can_accept_o = reserved < (CntW + 1)'(irot_pkg::QUEUE_DEPTH);

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + CntW'(push_i) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      pix_q[wr_ptr_q]  <= push_pixel_i;
      last_q[wr_ptr_q] <= push_last_i;
    end
  end

endmodule

/* src/image_rotate_90_clockwise.sv */
// ----------------------------------------------------------------------------
// image_rotate_90_clockwise: streaming square frame rotator
// Rotates square frames of pixels by 90 degrees clockwise through a
// ping-pong frame store.
// ----------------------------------------------------------------------------
// Square frames arrive one pixel per item in row-major order. A push item
// writes its pixel into the bank being filled; when the last pixel of a
// frame is written the banks swap and that frame becomes the held frame.
// Every item, push or drain, also emits the next pixel of the held frame
// in rotated order, if a frame is held: output (r,c) is input (size-1-c, r),
// and frame_last_o marks the final pixel. A new frame that completes while
// the old one is still being read replaces it. The block takes one item per
// clock cycle; the frame store does one write and one read per cycle, and a
// result is registered in the front, then queued before the output. A
// four-entry result queue absorbs output stalls, so items keep flowing until
// it fills. Writing side_length (clamped to 1..MAX_SIDE) drops the partial
// frame and the held frame. Configuration may only be written while idle.
// ----------------------------------------------------------------------------
module image_rotate_90_clockwise #(
  parameter int unsigned MAX_SIDE   = 32,
  parameter int unsigned PIXEL_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [irot_pkg::SIDE_CFG_W-1:0] side_length_i,
  // Input item channel.
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            mode_i,
  input  logic [PIXEL_BITS-1:0]           pixel_in_i,
  // Result item channel.
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [PIXEL_BITS-1:0]           pixel_out_o,
  output logic                            frame_last_o
);

  logic                  q_can_accept;
  logic                  rd_push;
  logic [PIXEL_BITS-1:0] rd_pixel;
  logic                  rd_last;

  // Configuration writes are always taken; the user must write them only while idle, the block does not enforce it.
  assign cfg_ready_o = 1'b1;

  // The front handles intake, pointers and the store.
  irot_front #(
    .MAX_SIDE   (MAX_SIDE),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .pixel_in_i     (pixel_in_i),
    .cfg_write_i    (cfg_valid_i),
    .side_length_i  (side_length_i),
    .q_can_accept_i (q_can_accept),
    .rd_push_o      (rd_push),
    .rd_pixel_o     (rd_pixel),
    .rd_last_o      (rd_last)
  );

  // The back holds rotated pixels until the output side takes them.
  irot_queue #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (rd_push),
    .push_pixel_i (rd_pixel),
    .push_last_i  (rd_last),
    .can_accept_o (q_can_accept),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_out_o  (pixel_out_o),
    .frame_last_o (frame_last_o)
  );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the 90-degree image rotator
// Streams square frames through the block under changing side lengths and
// idling patterns, and checks every rotated pixel against a local model.
// ----------------------------------------------------------------------------
// A clocked driver takes items from a queue that the stimulus process fills.
// When an item is accepted, the driver runs it through a local copy of the
// ping-pong frame store and queues the pixel that item should emit, if any.
// A clocked monitor pops that queue for each result item and compares the
// pixel and the frame-last flag. The side length is only changed while the
// block is quiet. The stimulus opens with a short directed part (no frame
// held, the clamp of zero to one, a two-by-two rotation), then one full
// frame at the largest size written as an oversized value, a back-pressure
// episode, and several phases of small random frames mixed with drain items.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned MAX_SIDE      = 32;
  localparam int unsigned PIXEL_BITS    = 32;
  // A result passes the front's read register and the result queue; wait well past that before
  // touching the side length, since drain items may produce nothing.
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES   = 120;
  localparam int unsigned RANDOM_ITEMS  = 100;
  localparam int unsigned MIN_PHASES    = 4;
  localparam int unsigned MAX_REPORTS   = 10;

  // Who is allowed to idle during the current phase.
  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic                  mode;
    logic [PIXEL_BITS-1:0] pixel;
  } pixel_item_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel;
    logic                  last;
  } rotated_pixel_t;

  // Signals toward the block. Everything starts at a known value.
  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            cfg_valid  = 1'b0;
  logic                            cfg_ready;
  logic [irot_pkg::SIDE_CFG_W-1:0] side_cfg   = '0;
  logic                            in_valid   = 1'b0;
  logic                            in_ready;
  logic                            mode       = irot_pkg::MODE_DRAIN;
  logic [PIXEL_BITS-1:0]           pixel_in   = '0;
  logic                            out_valid;
  logic                            out_ready  = 1'b0;
  logic [PIXEL_BITS-1:0]           pixel_out;
  logic                            frame_last;

  // Stimulus control.
  idle_mode_e            idle_mode  = IDLE_NONE;
  logic                  hold_go    = 1'b0;
  logic                  hold_off   = 1'b0;

  // Items waiting for the driver, and pixels waiting for the monitor.
  pixel_item_t           pending_items[$];
  rotated_pixel_t        rotated_expect[$];

  // Local model of the frame store and its pointers.
  logic [PIXEL_BITS-1:0]           frame_store [2][MAX_SIDE][MAX_SIDE];
  int unsigned                     wr_row, wr_col, rd_row, rd_col;
  logic                            wr_bank;
  logic                            frame_held;
  logic [irot_pkg::SIDE_CFG_W-1:0] side_reg;

  // Run statistics.
  int unsigned           items_sent;
  int unsigned           pixels_seen;
  int unsigned           frames_seen;
  int unsigned           side_writes;
  int unsigned           mismatches;

  image_rotate_90_clockwise #(
    .MAX_SIDE  (MAX_SIDE),
    .PIXEL_BITS(PIXEL_BITS)
  ) i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .side_length_i(side_cfg),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .mode_i       (mode),
    .pixel_in_i   (pixel_in),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .pixel_out_o  (pixel_out),
    .frame_last_o (frame_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The register holds six bits; zero acts as one and anything above the
  // store size is clamped to it.
  function automatic int unsigned frame_side();
    if (side_reg == '0) return 1;
    if (side_reg > MAX_SIDE) return MAX_SIDE;
    return side_reg;
  endfunction

  // A side length write drops the partial frame and the held frame but
  // leaves the bank selection alone.
  function automatic void apply_side(input logic [irot_pkg::SIDE_CFG_W-1:0] value);
    side_reg   = value;
    wr_row     = 0;
    wr_col     = 0;
    rd_row     = 0;
    rd_col     = 0;
    frame_held = 1'b0;
  endfunction

  // One accepted item: the held frame emits first, then a push item writes.
  // Rotated position (r,c) reads the stored pixel at (side-1-c, r).
  function automatic void rotate_item(input logic item_mode,
                                      input logic [PIXEL_BITS-1:0] item_pixel);
    int unsigned    n;
    rotated_pixel_t emitted;
    n = frame_side();
    if (frame_held) begin
      emitted.pixel = frame_store[~wr_bank][n - 1 - rd_col][rd_row];
      emitted.last  = (rd_row == n - 1) && (rd_col == n - 1);
      rotated_expect.push_back(emitted);
      if (emitted.last) begin
        frame_held = 1'b0;
        rd_row     = 0;
        rd_col     = 0;
      end else if (rd_col + 1 >= n) begin
        rd_col = 0;
        rd_row++;
      end else begin
        rd_col++;
      end
    end
    if (item_mode == irot_pkg::MODE_PUSH) begin
      frame_store[wr_bank][wr_row][wr_col] = item_pixel;
      if (wr_col + 1 >= n) begin
        wr_col = 0;
        if (wr_row + 1 >= n) begin
          // Frame complete: swap banks and start reading it from the top.
          wr_row     = 0;
          wr_bank    = ~wr_bank;
          frame_held = 1'b1;
          rd_row     = 0;
          rd_col     = 0;
        end else begin
          wr_row++;
        end
      end else begin
        wr_col++;
      end
    end
  endfunction

  // Driver: records the accepted item in the model, then offers the next
  // one unless the sender is idling. Valid only drops when no item is
  // offered, so it is never lowered and raised in the same step.
  always @(posedge clk or negedge rst_n) begin
    pixel_item_t next_item;
    logic        idle_now;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        rotate_item(mode, pixel_in);
        items_sent++;
      end
      if (!in_valid || in_ready) begin
        case (idle_mode)
          IDLE_SENDER: idle_now = ($urandom_range(99) < 79);
          IDLE_BOTH:   idle_now = ($urandom_range(99) < 12);
          default:     idle_now = 1'b0;
        endcase
        if (pending_items.size() != 0 && !idle_now) begin
          next_item = pending_items.pop_front();
          in_valid  <= 1'b1;
          mode      <= next_item.mode;
          pixel_in  <= next_item.pixel;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest expected pixel
  // and picks the ready level for the next cycle.
  always @(posedge clk or negedge rst_n) begin
    rotated_pixel_t wanted;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        pixels_seen++;
        if (frame_last === 1'b1) frames_seen++;
        if (rotated_expect.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected pixel %h last %b", $realtime, pixel_out, frame_last);
        end else begin
          wanted = rotated_expect.pop_front();
          if (pixel_out !== wanted.pixel || frame_last !== wanted.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: pixel mismatch, expected %h last %b, got %h last %b",
                       $realtime, wanted.pixel, wanted.last, pixel_out, frame_last);
          end
        end
      end
      if (hold_off)
        out_ready <= 1'b0;
      else if (idle_mode == IDLE_RECEIVER)
        out_ready <= ($urandom_range(99) >= 79);
      else if (idle_mode == IDLE_BOTH)
        out_ready <= ($urandom_range(99) >= 12);
      else
        out_ready <= 1'b1;
    end
  end

  // Long receiver hold-off, counted here once the stimulus asks for it.
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Mostly random pixels, with the all-zero and all-one words mixed in.
  function automatic logic [PIXEL_BITS-1:0] random_pixel();
    case ($urandom_range(19))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic void queue_item(input logic item_mode,
                                     input logic [PIXEL_BITS-1:0] item_pixel);
    pixel_item_t it;
    it.mode  = item_mode;
    it.pixel = item_pixel;
    pending_items.push_back(it);
  endfunction

  // A run of push and drain items with random pixels.
  function automatic void queue_mix(input int unsigned count, input int unsigned push_pct);
    for (int unsigned i = 0; i < count; i++)
      queue_item(($urandom_range(99) < push_pct) ? irot_pkg::MODE_PUSH : irot_pkg::MODE_DRAIN,
                 random_pixel());
  endfunction

  // Waits until every queued item has gone in and every expected pixel has
  // come out, lets in-flight items settle, and returns between edges.
  task automatic wait_quiet();
    while (pending_items.size() != 0 || in_valid || rotated_expect.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_side(input logic [irot_pkg::SIDE_CFG_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    side_cfg  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_side(value);
    side_writes++;
    @(negedge clk);
  endtask

  task automatic start_phase(input logic [irot_pkg::SIDE_CFG_W-1:0] value,
                             input idle_mode_e idling);
    wait_quiet();
    write_side(value);
    idle_mode <= idling;
    @(negedge clk);
  endtask

  // Stimulus.
  initial begin
    int unsigned random_queued;
    int unsigned phase;
    int unsigned n;
    int unsigned count;
    logic [irot_pkg::SIDE_CFG_W-1:0] side_pick;

    for (int b = 0; b < 2; b++)
      for (int r = 0; r < MAX_SIDE; r++)
        for (int c = 0; c < MAX_SIDE; c++)
          frame_store[b][r][c] = '0;
    wr_bank     = 1'b0;
    apply_side(irot_pkg::SIDE_CFG_W'(irot_pkg::SIDE_RESET));
    items_sent  = 0;
    pixels_seen = 0;
    frames_seen = 0;
    side_writes = 0;
    mismatches  = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset size, no frame held: drains and a lone push give nothing, and
    // the partial frame is dropped by the next side length write.
    queue_item(irot_pkg::MODE_DRAIN, '1);
    queue_item(irot_pkg::MODE_PUSH, '1);
    queue_item(irot_pkg::MODE_DRAIN, '0);

    // Side length zero acts as one: each push completes a frame, and the
    // pixel held from the previous push is emitted as a last pixel first.
    start_phase('0, IDLE_NONE);
    queue_item(irot_pkg::MODE_PUSH, '0);
    queue_item(irot_pkg::MODE_PUSH, '1);
    queue_item(irot_pkg::MODE_DRAIN, '0);
    queue_item(irot_pkg::MODE_DRAIN, '1);

    // Two by two: rows {A,B},{C,D} come out as C, A, D, B. A second frame
    // pushed right behind keeps both banks busy.
    start_phase(6'd2, IDLE_NONE);
    queue_item(irot_pkg::MODE_PUSH, 32'h0000_000a);
    queue_item(irot_pkg::MODE_PUSH, 32'h0000_000b);
    queue_item(irot_pkg::MODE_PUSH, 32'h0000_000c);
    queue_item(irot_pkg::MODE_PUSH, 32'h0000_000d);
    queue_item(irot_pkg::MODE_DRAIN, '0);
    queue_item(irot_pkg::MODE_PUSH, 32'hffff_0000);
    queue_item(irot_pkg::MODE_PUSH, 32'h0000_ffff);
    queue_item(irot_pkg::MODE_DRAIN, '0);
    queue_item(irot_pkg::MODE_PUSH, 32'h5555_5555);
    queue_item(irot_pkg::MODE_PUSH, 32'haaaa_aaaa);
    queue_item(irot_pkg::MODE_DRAIN, '0);
    queue_item(irot_pkg::MODE_DRAIN, '0);
    queue_item(irot_pkg::MODE_DRAIN, '0);

    // All-ones register value saturates to the full store size: one whole
    // frame in, then the first row of the rotated frame out. The rest is
    // dropped by the next side length write.
    start_phase('1, IDLE_NONE);
    queue_mix(MAX_SIDE * MAX_SIDE, 100);
    queue_mix(MAX_SIDE, 75);

    // Back-pressure: with a frame held, the receiver holds off for a long
    // stretch while pushes keep coming, so the result queue fills and the
    // input stalls. The next phase start waits for every pixel to drain.
    start_phase(6'd4, IDLE_NONE);
    queue_mix(16, 100);
    hold_go = 1'b1;
    queue_mix(24, 90);

    // Random phases: mostly small frames, now and then a mid-size one or an
    // out-of-range register value. Idling rotates through all patterns.
    random_queued = 0;
    phase = 0;
    while (random_queued < RANDOM_ITEMS || phase < MIN_PHASES) begin
      case ($urandom_range(9))
        0:       side_pick = 6'($urandom_range(9, 16));
        1:       side_pick = 6'($urandom_range(33, 63));
        2:       side_pick = '0;
        default: side_pick = 6'($urandom_range(1, 8));
      endcase
      start_phase(side_pick, idle_mode_e'(phase % 4));
      n = frame_side();
      count = 2 * n * n + $urandom_range(4, 12);
      if (count > 48) count = $urandom_range(16, 48);
      queue_mix(count, 80);
      random_queued += count;
      phase++;
    end

    wait_quiet();
    $display("Sent %0d items over %0d side length settings and %0d random phases.",
             items_sent, side_writes, phase);
    $display("Checked %0d rotated pixels in %0d completed frames.", pixels_seen, frames_seen);
    if (mismatches == 0 && rotated_expect.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* files.f */
src/irot_pkg.sv
src/irot_front.sv
src/irot_queue.sv
src/image_rotate_90_clockwise.sv
tb/testbench.sv
